FILE: hdl/sphere_pair_event_time_macros.svh
// Assertion macros used by the checker file spet_checker.sv.
`ifndef SPHERE_PAIR_EVENT_TIME_MACROS_SVH
`define SPHERE_PAIR_EVENT_TIME_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SPET_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("spet: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SPET_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("spet: next-cycle check failed");

`endif

FILE: hdl/spet_pkg.sv
// ----------------------------------------------------------------------------
// spet_pkg
// Shared constants and sideband types for the sphere pair event time block.
// ----------------------------------------------------------------------------
`default_nettype none

package spet_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // square root unit: 64-bit radicand, 32 root bits, one bit per cell
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int SQ_REM_W = 34;

    // magnitude widths of numerator base and divisor
    localparam int NB_W  = 33;
    localparam int DEN_W = 33;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] b;
        logic [30:0]        v2;
        logic signed [31:0] diff;
        logic               ok;
        logic               ovl;
    } t_sq_side;

    typedef struct packed {
        logic neg;
        logic ok;
        logic ovl;
    } t_dv_side;

endpackage

`default_nettype wire

FILE: hdl/spet_sqrt_cell.sv
// ----------------------------------------------------------------------------
// spet_sqrt_cell
// One root bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spet_sqrt_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [spet_pkg::RAD_W-1:0]        i_rad,
    input  wire logic [spet_pkg::SQ_REM_W-1:0]     i_rem,
    input  wire logic [spet_pkg::ROOT_W-1:0]       i_root,
    input  wire spet_pkg::t_sq_side                i_side,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [spet_pkg::RAD_W-1:0]             o_rad,
    output logic [spet_pkg::SQ_REM_W-1:0]          o_rem,
    output logic [spet_pkg::ROOT_W-1:0]            o_root,
    output spet_pkg::t_sq_side                     o_side
);
    import spet_pkg::*;

    logic                  w_en;
    logic [SQ_REM_W+1:0]   w_acc;
    logic [SQ_REM_W+1:0]   w_trial;
    logic [SQ_REM_W+1:0]   w_diff;
    logic                  w_ge;
    logic                  r_v;
    logic [RAD_W-1:0]      r_rad;
    logic [SQ_REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]     r_root;
    t_sq_side              r_side;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;

    assign w_acc   = {i_rem, i_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, i_root, 2'b01};
    assign w_ge    = (w_acc >= w_trial);
    assign w_diff  = w_acc - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[SQ_REM_W-1:0] : w_acc[SQ_REM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_rad   = r_rad;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

`default_nettype wire

FILE: hdl/spet_div_cell.sv
// ----------------------------------------------------------------------------
// spet_div_cell
// One quotient bit of a restoring unsigned division, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spet_div_cell #(
    parameter int NUM_W = spet_pkg::NB_W + spet_pkg::FRAC_BITS_DEF,
    parameter int DIV_W = spet_pkg::DEN_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [NUM_W-1:0]  i_nq,
    input  wire logic [DIV_W-1:0]  i_rem,
    input  wire logic [DIV_W-1:0]  i_den,
    input  wire spet_pkg::t_dv_side i_side,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [NUM_W-1:0]       o_nq,
    output logic [DIV_W-1:0]       o_rem,
    output logic [DIV_W-1:0]       o_den,
    output spet_pkg::t_dv_side     o_side
);
    import spet_pkg::*;

    logic              w_en;
    logic [DIV_W:0]    w_acc;
    logic [DIV_W:0]    w_diff;
    logic              w_ge;
    logic              r_v;
    logic [NUM_W-1:0]  r_nq;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    t_dv_side          r_side;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;

    // dividend bits leave the top of nq while quotient bits enter the bottom
    assign w_acc  = {i_rem, i_nq[NUM_W-1]};
    assign w_ge   = (w_acc >= {1'b0, i_den});
    assign w_diff = w_acc - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nq   <= {i_nq[NUM_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[DIV_W-1:0] : w_acc[DIV_W-1:0];
            r_den  <= i_den;
            r_side <= i_side;
        end
    end

    assign o_valid = r_v;
    assign o_nq    = r_nq;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

`default_nettype wire

FILE: hdl/sphere_pair_event_time.sv
// ----------------------------------------------------------------------------
// sphere_pair_event_time
// Hard-sphere pair entry/exit time from the quadratic, fixed point.
//
//  channel | handshake          | word
//  --------+--------------------+---------------------------------------------
//  input   | i_valid / o_ready  | mode, pos_vel_dot, speed_sq, sep_sq, contact
//  output  | o_valid / i_ready  | found, event_time, overlapping
//
// One word per cycle sustained unless the output stalls. The stages are:
// three front stages (operands, products, discriminant), 32 square root
// cells, one operand setup stage, one divider cell per quotient bit, and
// the output register. Reset clears every valid bit. A stall at the output
// backs up only as far as the first empty cell; bubbles collapse.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_pair_event_time #(
    parameter int DATA_WIDTH = spet_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = spet_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_mode,
    input  wire logic [31:0] i_pos_vel_dot,
    input  wire logic [30:0] i_speed_sq,
    input  wire logic [30:0] i_sep_sq,
    input  wire logic [30:0] i_contact_sq,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic [31:0]      o_event_time,
    output logic             o_overlapping
);
    import spet_pkg::*;

    localparam int NUM_W = NB_W + FRAC_BITS;
    localparam logic [63:0] T_HI = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;

    // ---------------- front stages ----------------
    logic               en0, en1, en2, en3, en4;
    logic               r0_v, r1_v, r2_v, r3_v, r4_v;
    logic               r0_mode, r1_mode, r2_mode;
    logic signed [31:0] r0_b, r1_b, r2_b;
    logic [30:0]        r0_v2, r1_v2, r2_v2;
    logic signed [31:0] r0_diff, r1_diff, r2_diff;
    logic signed [63:0] r1_bb, r1_vd, r2_disc;
    logic signed [63:0] w_disc;
    logic               w_ok;

    logic               w_sq_v   [0:ROOT_W];
    logic               w_sq_rdy [0:ROOT_W];
    logic [RAD_W-1:0]   w_rad    [0:ROOT_W];
    logic [SQ_REM_W-1:0] w_srem  [0:ROOT_W];
    logic [ROOT_W-1:0]  w_root   [0:ROOT_W];
    t_sq_side           w_sside  [0:ROOT_W];

    logic               w_dv_v   [0:NUM_W];
    logic               w_dv_rdy [0:NUM_W];
    logic [NUM_W-1:0]   w_nq     [0:NUM_W];
    logic [DEN_W-1:0]   w_drem   [0:NUM_W];
    logic [DEN_W-1:0]   w_den    [0:NUM_W];
    t_dv_side           w_dside  [0:NUM_W];

    assign en0     = !r0_v || en1;
    assign en1     = !r1_v || en2;
    assign en2     = !r2_v || w_sq_rdy[0];
    assign o_ready = en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else begin
            if (en0) begin
                r0_v <= i_valid;
            end
            if (en1) begin
                r1_v <= r0_v;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r0_mode <= i_mode;
            r0_b    <= $signed(i_pos_vel_dot);
            r0_v2   <= i_speed_sq;
            r0_diff <= $signed({1'b0, i_sep_sq}) - $signed({1'b0, i_contact_sq});
        end
        if (en1) begin
            r1_mode <= r0_mode;
            r1_b    <= r0_b;
            r1_v2   <= r0_v2;
            r1_diff <= r0_diff;
            r1_bb   <= r0_b * r0_b;
            r1_vd   <= $signed({1'b0, r0_v2}) * r0_diff;
        end
        if (en2) begin
            r2_mode <= r1_mode;
            r2_b    <= r1_b;
            r2_v2   <= r1_v2;
            r2_diff <= r1_diff;
            r2_disc <= r1_bb - r1_vd;
        end
    end

    assign w_disc = r2_disc;
    assign w_ok   = r2_mode ? (!w_disc[63] && (r2_v2 != '0))
                            : (r2_b[31] && !w_disc[63] && (w_disc != '0));

    // ---------------- square root chain ----------------
    assign w_sq_v[0]          = r2_v;
    assign w_rad[0]           = w_ok ? w_disc : '0;
    assign w_srem[0]          = '0;
    assign w_root[0]          = '0;
    assign w_sside[0].mode    = r2_mode;
    assign w_sside[0].b       = r2_b;
    assign w_sside[0].v2      = r2_v2;
    assign w_sside[0].diff    = r2_diff;
    assign w_sside[0].ok      = w_ok;
    assign w_sside[0].ovl     = r2_diff[31];
    assign w_sq_rdy[ROOT_W]   = en3;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sq
        spet_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_v[k]),
            .o_ready (w_sq_rdy[k]),
            .i_rad   (w_rad[k]),
            .i_rem   (w_srem[k]),
            .i_root  (w_root[k]),
            .i_side  (w_sside[k]),
            .o_valid (w_sq_v[k+1]),
            .i_ready (w_sq_rdy[k+1]),
            .o_rad   (w_rad[k+1]),
            .o_rem   (w_srem[k+1]),
            .o_root  (w_root[k+1]),
            .o_side  (w_sside[k+1])
        );
    end

    // ---------------- divider operand setup ----------------
    t_sq_side         w_ss;
    logic [NB_W-1:0]  n_nmag;
    logic [DEN_W-1:0] n_dmag;
    logic             n_neg;
    logic [NUM_W-1:0] r3_nq;
    logic [DEN_W-1:0] r3_den;
    t_dv_side         r3_side;

    assign w_ss = w_sside[ROOT_W];

    always_comb begin
        logic signed [33:0] v_den;
        logic signed [33:0] v_nden;
        logic signed [33:0] v_nb;
        logic signed [33:0] v_nnb;
        v_den  = {{2{w_ss.b[31]}}, w_ss.b} - $signed({2'b00, w_root[ROOT_W]});
        v_nden = -v_den;
        if (w_ss.mode) begin
            v_nb   = $signed({2'b00, w_root[ROOT_W]}) - {{2{w_ss.b[31]}}, w_ss.b};
            n_dmag = {2'b00, w_ss.v2};
            n_neg  = v_nb[33];
        end else begin
            v_nb   = -{{2{w_ss.diff[31]}}, w_ss.diff};
            n_dmag = v_nden[DEN_W-1:0];
            n_neg  = !v_nb[33];
        end
        v_nnb  = -v_nb;
        n_nmag = v_nb[33] ? v_nnb[NB_W-1:0] : v_nb[NB_W-1:0];
    end

    assign en3 = !r3_v || w_dv_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en3) begin
            r3_v <= w_sq_v[ROOT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_nq       <= {n_nmag, {FRAC_BITS{1'b0}}};
            r3_den      <= n_dmag;
            r3_side.neg <= n_neg;
            r3_side.ok  <= w_ss.ok;
            r3_side.ovl <= w_ss.ovl;
        end
    end

    // ---------------- divider chain ----------------
    assign w_dv_v[0]       = r3_v;
    assign w_nq[0]         = r3_nq;
    assign w_drem[0]       = '0;
    assign w_den[0]        = r3_den;
    assign w_dside[0]      = r3_side;
    assign w_dv_rdy[NUM_W] = en4;

    for (genvar k = 0; k < NUM_W; k++) begin : g_dv
        spet_div_cell #(
            .NUM_W (NUM_W),
            .DIV_W (DEN_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv_v[k]),
            .o_ready (w_dv_rdy[k]),
            .i_nq    (w_nq[k]),
            .i_rem   (w_drem[k]),
            .i_den   (w_den[k]),
            .i_side  (w_dside[k]),
            .o_valid (w_dv_v[k+1]),
            .i_ready (w_dv_rdy[k+1]),
            .o_nq    (w_nq[k+1]),
            .o_rem   (w_drem[k+1]),
            .o_den   (w_den[k+1]),
            .o_side  (w_dside[k+1])
        );
    end

    // ---------------- sign, saturation, output register ----------------
    t_dv_side    w_ds;
    logic [63:0] w_qx;
    logic [63:0] w_nqx;
    logic [63:0] n_t;
    logic        r4_found;
    logic [31:0] r4_time;
    logic        r4_ovl;

    assign w_ds  = w_dside[NUM_W];
    assign w_qx  = 64'(w_nq[NUM_W]);
    assign w_nqx = -w_qx;

    always_comb begin
        if (!w_ds.ok) begin
            n_t = T_HI;
        end else if (!w_ds.neg) begin
            n_t = (w_qx > T_HI) ? T_HI : w_qx;
        end else begin
            n_t = (w_qx > T_HI + 64'd1) ? ~T_HI : w_nqx;
        end
    end

    assign en4 = !r4_v || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en4) begin
            r4_v <= w_dv_v[NUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_found <= w_ds.ok;
            r4_time  <= n_t[31:0];
            r4_ovl   <= w_ds.ovl;
        end
    end

    assign o_valid       = r4_v;
    assign o_found       = r4_found;
    assign o_event_time  = r4_time;
    assign o_overlapping = r4_ovl;

endmodule

`default_nettype wire

FILE: hdl/spet_checker.sv
// ----------------------------------------------------------------------------
// spet_checker
// Port-level checks for the sphere pair event time block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sphere_pair_event_time_macros.svh"

module spet_checker #(
    parameter int DATA_WIDTH = spet_pkg::DATA_WIDTH_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic        o_found,
    input wire logic [31:0] o_event_time
);
    localparam logic [63:0] T_HI = (64'd1 << (DATA_WIDTH - 1)) - 64'd1;
    localparam logic [31:0] T_MAX = T_HI[31:0];

    // a stalled word stays put
    `SPET_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_event_time))
    // no result means the saturated maximum
    `SPET_ASSERT_NOW(a_miss_max, o_valid && !o_found, o_event_time == T_MAX)
    // an empty output register lets the whole chain move
    `SPET_ASSERT_NOW(a_empty_ready, !o_valid, o_ready)
    // output taken means every cell may advance
    `SPET_ASSERT_NOW(a_drain_ready, i_ready, o_ready)

endmodule

bind sphere_pair_event_time spet_checker #(.DATA_WIDTH(DATA_WIDTH)) u_spet_checker (.*);

`default_nettype wire

FILE: bench/tb_sphere_pair_event_time.sv
// ----------------------------------------------------------------------------
// tb_sphere_pair_event_time
// Self-checking bench for the hard-sphere pair event time block.
// Each accepted word is predicted by a bit-accurate model in the bench. The
// expectations are queued in order and compared field by field against every
// result word. The run covers directed corner cases, random well-formed and
// raw stimulus, random idling on both sides, a long output stall and a drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sphere_pair_event_time;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          PIPE_DEPTH = 37 + 33 + 16;
    localparam logic [31:0] TIME_MAX   = 32'h7FFF_FFFF;

    typedef enum logic {MODE_ENTRY = 1'b0, MODE_EXIT = 1'b1} t_mode;

    typedef struct packed {
        logic        found;
        logic [31:0] event_time;
        logic        overlapping;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_mode = 1'b0;
    logic [31:0] i_pos_vel_dot = '0;
    logic [30:0] i_speed_sq = '0;
    logic [30:0] i_sep_sq = '0;
    logic [30:0] i_contact_sq = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_found;
    logic [31:0] o_event_time;
    logic        o_overlapping;

    t_event pending_events[$];
    int     error_count = 0;
    bit     tx_idle_on = 1'b1;
    bit     rx_idle_on = 1'b1;
    bit     rx_hold_req = 1'b0;

    always #2 i_clk = ~i_clk;

    sphere_pair_event_time u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_mode        (i_mode),
        .i_pos_vel_dot (i_pos_vel_dot),
        .i_speed_sq    (i_speed_sq),
        .i_sep_sq      (i_sep_sq),
        .i_contact_sq  (i_contact_sq),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_event_time  (o_event_time),
        .o_overlapping (o_overlapping)
    );

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bt;
        r  = '0;
        bt = 64'h1 << 62;
        while (bt > x) bt = bt >> 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_time(logic signed [79:0] q);
        if (q > 80'sd2147483647) return TIME_MAX;
        if (q < -80'sd2147483648) return 32'h8000_0000;
        return q[31:0];
    endfunction

    function automatic t_event pair_event(t_mode mode, logic [31:0] b, logic [30:0] v2,
                                          logic [30:0] r2, logic [30:0] d2);
        logic signed [79:0] bw, v2w, r2w, d2w, disc, root, num, den;
        t_event ev;
        bw   = $signed(b);
        v2w  = {49'b0, v2};
        r2w  = {49'b0, r2};
        d2w  = {49'b0, d2};
        disc = bw * bw - v2w * (r2w - d2w);
        ev.found       = 1'b0;
        ev.event_time  = TIME_MAX;
        ev.overlapping = (r2 < d2);
        if (mode == MODE_ENTRY) begin
            if (bw < 0 && disc > 0) begin
                root = {16'b0, floor_root(disc[63:0])};
                num  = (d2w - r2w) <<< 16;
                den  = bw - root;
                ev.event_time = clamp_time(num / den);
                ev.found = 1'b1;
            end
        end else begin
            if (disc >= 0 && v2 != 0) begin
                root = {16'b0, floor_root(disc[63:0])};
                num  = (root - bw) <<< 16;
                ev.event_time = clamp_time(num / v2w);
                ev.found = 1'b1;
            end
        end
        return ev;
    endfunction

    // one word, waits for acceptance and queues its prediction
    task automatic send_pair(t_mode mode, logic [31:0] b, logic [30:0] v2,
                             logic [30:0] r2, logic [30:0] d2);
        int gap;
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_pos_vel_dot <= b;
        i_speed_sq    <= v2;
        i_sep_sq      <= r2;
        i_contact_sq  <= d2;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_events.insert(pending_events.size(), pair_event(mode, b, v2, r2, d2));
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0) @(posedge i_clk);
    endtask

    // small magnitudes near contact, so roots usually exist
    task automatic send_formed(t_mode mode);
        logic [31:0] b;
        logic [30:0] v2, r2, d2;
        int span;
        span = 1 << $urandom_range(4, 24);
        b  = -$urandom_range(0, span);
        if ($urandom_range(0, 4) == 0) b = $urandom_range(0, span);
        v2 = 31'($urandom_range(0, span));
        d2 = 31'($urandom_range(0, span));
        r2 = 31'(d2 + $urandom_range(0, span / 4) - span / 8);
        if (r2[30]) r2 = '0;
        send_pair(mode, b, v2, r2, d2);
    endtask

    task automatic send_raw();
        send_pair(t_mode'($urandom_range(0, 1)), $urandom, 31'($urandom), 31'($urandom),
                  31'($urandom));
    endtask

    task automatic test_corners();
        logic [30:0] fmax;
        fmax = '1;
        send_pair(MODE_ENTRY, 32'h8000_0000, fmax, fmax, 31'd0);
        send_pair(MODE_ENTRY, 32'h7FFF_FFFF, fmax, 31'd0, fmax);
        send_pair(MODE_ENTRY, 32'h0001_0000, 31'h0001_0000, 31'h0004_0000, 31'h0001_0000);
        send_pair(MODE_ENTRY, 32'h0000_0000, 31'h0001_0000, 31'h0004_0000, 31'h0001_0000);
        // approaching but missing: no real root
        send_pair(MODE_ENTRY, -32'sh0000_0100, 31'h0001_0000, 31'h0010_0000, 31'h0001_0000);
        // grazing: discriminant exactly zero
        send_pair(MODE_ENTRY, -32'sd4, 31'd4, 31'd8, 31'd4);
        send_pair(MODE_ENTRY, -32'sh0002_0000, 31'h0001_0000, 31'h0009_0000, 31'h0001_0000);
        // already overlapping, negative time
        send_pair(MODE_ENTRY, -32'sh0001_0000, 31'h0001_0000, 31'h0000_4000, 31'h0001_0000);
        send_pair(MODE_ENTRY, -32'sd1, 31'd0, 31'd0, fmax);
        send_pair(MODE_ENTRY, -32'sd1, fmax, 31'd0, fmax);
        send_pair(MODE_EXIT, 32'h0000_0000, 31'h0001_0000, 31'h0000_4000, 31'h0001_0000);
        send_pair(MODE_EXIT, 32'h0001_0000, 31'h0000_0000, 31'h0000_4000, 31'h0001_0000);
        send_pair(MODE_EXIT, 32'h0001_0000, 31'h0001_0000, 31'h0010_0000, 31'h0001_0000);
        send_pair(MODE_EXIT, -32'sd4, 31'd4, 31'd8, 31'd4);
        send_pair(MODE_EXIT, -32'sh0001_0000, 31'd1, 31'd0, 31'd0);
        send_pair(MODE_EXIT, 32'h8000_0000, 31'd1, 31'd0, fmax);
        send_pair(MODE_EXIT, 32'h7FFF_FFFF, fmax, 31'd0, fmax);
        send_pair(MODE_EXIT, 32'h8000_0000, fmax, fmax, fmax);
        send_pair(MODE_EXIT, 32'hFFFF_FFFF, fmax, fmax, 31'd0);
        send_pair(MODE_ENTRY, 32'h8000_0000, 31'd1, 31'd0, fmax);
        end_burst();
    endtask

    task automatic test_random_mix(int n);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) send_raw();
            else send_formed(t_mode'($urandom_range(0, 1)));
        end
        end_burst();
    endtask

    task automatic test_output_stall();
        rx_hold_req = 1'b1;
        repeat (PIPE_DEPTH + 60) send_formed(t_mode'($urandom_range(0, 1)));
        end_burst();
    endtask

    task automatic test_drain_pause();
        repeat (40) send_formed(MODE_ENTRY);
        end_burst();
        wait_drained();
        repeat (40) send_formed(MODE_EXIT);
        end_burst();
    endtask

    task automatic test_streaming(int n);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (n) send_formed(t_mode'($urandom_range(0, 1)));
        end_burst();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random_mix(1000);
        test_output_stall();
        test_drain_pause();
        test_random_mix(200);
        test_streaming(250);
        wait_drained();
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // receiver: random ready bursts, one long hold on request
    initial begin
        int n;
        forever begin
            if (rx_hold_req) begin
                i_ready <= 1'b0;
                n = 0;
                while (n < 4 * PIPE_DEPTH) begin
                    @(posedge i_clk);
                    n++;
                end
                rx_hold_req = 1'b0;
            end else if (!rx_idle_on) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
                if (!rx_idle_on || rx_hold_req) continue;
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected result word");
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    error_count++;
                end
                if (o_event_time !== want.event_time) begin
                    $error("event_time: expected %h, got %h", want.event_time, o_event_time);
                    error_count++;
                end
                if (o_overlapping !== want.overlapping) begin
                    $error("overlapping: expected %0d, got %0d",
                           want.overlapping, o_overlapping);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #4ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
